### src/bitp_pkg.sv
// shared types and constants for the boolean infix to postfix tree builder
// no dependencies
package bitp_pkg;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int MAX_VARS_DEF    = 16;
    localparam int MAX_NODES_DEF   = 64;

    localparam logic [6:0] C_NOT   = 7'h21;
    localparam logic [6:0] C_AND   = 7'h2a;
    localparam logic [6:0] C_OR    = 7'h2b;
    localparam logic [6:0] C_IMP   = 7'h3e;
    localparam logic [6:0] C_EQV   = 7'h3d;
    localparam logic [6:0] C_OPEN  = 7'h28;
    localparam logic [6:0] C_CLOSE = 7'h29;

    localparam logic [1:0] K_VAR   = 2'd0;
    localparam logic [1:0] K_NODE  = 2'd1;
    localparam logic [1:0] K_DIGIT = 2'd2;
    localparam logic [1:0] K_NONE  = 2'd3;

    localparam logic [1:0] R_OPND = 2'd0;
    localparam logic [1:0] R_OPR  = 2'd1;
    localparam logic [1:0] R_DONE = 2'd2;

    localparam logic [2:0] E_OK    = 3'd0;
    localparam logic [2:0] E_MISS  = 3'd1;
    localparam logic [2:0] E_OVF   = 3'd2;
    localparam logic [2:0] E_VARS  = 3'd3;
    localparam logic [2:0] E_PAREN = 3'd4;
    localparam logic [2:0] E_NODES = 3'd5;

    // datapath commands
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_CHAR   = 3'd1; // classify and take simple char
    localparam logic [2:0] CMD_POP    = 3'd2; // pop top operator, make node
    localparam logic [2:0] CMD_PUSH   = 3'd3; // push the held operator
    localparam logic [2:0] CMD_DROPP  = 3'd4; // drop '(' or flag stray ')'
    localparam logic [2:0] CMD_DONE   = 3'd5; // emit done and clear
    localparam logic [2:0] CMD_VSCAN  = 3'd6; // compare one table entry
    localparam logic [2:0] CMD_FLUSHP = 3'd7; // discard '(' at flush and flag

    typedef struct packed {
        logic [2:0] cmd;
    } t_cmd;

    typedef struct packed {
        logic is_ws;
        logic is_opnd;
        logic is_letter;
        logic is_open;
        logic is_close;
        logic is_not;
        logic op_empty;
        logic top_open;
        logic top_pops;  // top has prec >= held char prec
        logic vscan_end;
        logic last;
        logic out_busy;
    } t_stat;

    function automatic logic signed [2:0] prec(input logic [6:0] c);
        case (c)
            C_NOT:        prec = 3'sd3;
            C_AND:        prec = 3'sd2;
            C_OR:         prec = 3'sd1;
            C_IMP, C_EQV: prec = 3'sd0;
            default:      prec = -3'sd1;
        endcase
    endfunction
endpackage

### src/bitp_ctrl.sv
// controller state machine for the shunting-yard parser
// depends on bitp_pkg
module bitp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  bitp_pkg::t_stat i_stat,
    output bitp_pkg::t_cmd  o_cmd
);
    import bitp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_VSCAN = 3'd2;
    localparam logic [2:0] S_CLOSE = 3'd3;
    localparam logic [2:0] S_OPER  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0] r_state, n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        o_cmd.cmd = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DEC;
            end
            S_DEC: begin
                if (i_stat.is_ws) begin
                    n_state = i_stat.last ? S_FLUSH : S_IDLE;
                end else if (i_stat.is_letter) begin
                    n_state = S_VSCAN;
                end else if (i_stat.is_opnd || i_stat.is_open) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.cmd = CMD_CHAR;
                        n_state = i_stat.last ? S_FLUSH : S_IDLE;
                    end
                end else if (i_stat.is_close) begin
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_OPER;
                end
            end
            S_VSCAN: begin
                if (i_stat.vscan_end) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.cmd = CMD_CHAR;
                        n_state = i_stat.last ? S_FLUSH : S_IDLE;
                    end
                end else begin
                    o_cmd.cmd = CMD_VSCAN;
                end
            end
            S_CLOSE: begin
                if (!i_stat.op_empty && !i_stat.top_open) begin
                    if (!i_stat.out_busy) o_cmd.cmd = CMD_POP;
                end else begin
                    o_cmd.cmd = CMD_DROPP;
                    n_state = i_stat.last ? S_FLUSH : S_IDLE;
                end
            end
            S_OPER: begin
                if (!i_stat.is_not && !i_stat.op_empty && !i_stat.top_open
                        && i_stat.top_pops) begin
                    if (!i_stat.out_busy) o_cmd.cmd = CMD_POP;
                end else begin
                    o_cmd.cmd = CMD_PUSH;
                    n_state = i_stat.last ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (!i_stat.op_empty) begin
                    if (i_stat.top_open) o_cmd.cmd = CMD_FLUSHP;
                    else if (!i_stat.out_busy) o_cmd.cmd = CMD_POP;
                end else if (!i_stat.out_busy) begin
                    o_cmd.cmd = CMD_DONE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule

### src/bitp_dp.sv
// datapath: stacks, variable table, counters and output register
// depends on bitp_pkg
module bitp_dp #(
    parameter int STACK_DEPTH = bitp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_VARS    = bitp_pkg::MAX_VARS_DEF,
    parameter int MAX_NODES   = bitp_pkg::MAX_NODES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [6:0]      i_ch,
    input  logic            i_last,
    input  bitp_pkg::t_cmd  i_cmd,
    output bitp_pkg::t_stat o_stat,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_result_kind,
    output logic [6:0]      o_symbol,
    output logic [3:0]      o_var_index,
    output logic [1:0]      o_left_kind,
    output logic [5:0]      o_left_index,
    output logic [1:0]      o_right_kind,
    output logic [5:0]      o_right_index,
    output logic [5:0]      o_node_index,
    output logic [2:0]      o_status,
    output logic            o_end_of_run
);
    import bitp_pkg::*;

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int SC = $clog2(STACK_DEPTH + 1);
    localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int VC = $clog2(MAX_VARS + 1);
    localparam int NC = $clog2(MAX_NODES + 1);

    logic [6:0]    op_mem  [STACK_DEPTH];
    logic [7:0]    ref_mem [STACK_DEPTH];
    logic [6:0]    var_mem [MAX_VARS];

    logic [SC-1:0] r_op_cnt, r_ref_cnt;
    logic [VC-1:0] r_var_cnt, r_scan;
    logic [VW-1:0] r_hit_idx;
    logic          r_hit;
    logic [NC-1:0] r_node_cnt;
    logic [2:0]    r_err;
    logic [6:0]    r_ch;
    logic          r_last;

    logic [6:0]  top_op;
    logic [7:0]  ref_t, ref_u;
    logic        is_letter, is_digit;

    always_comb begin
        top_op = '0;
        ref_t  = '0;
        ref_u  = '0;
        if (r_op_cnt != '0) top_op = op_mem[SW'(r_op_cnt - 1'b1)];
        if (r_ref_cnt != '0) ref_t = ref_mem[SW'(r_ref_cnt - 1'b1)];
        if (r_ref_cnt > SC'(1)) ref_u = ref_mem[SW'(r_ref_cnt - SC'(2))];
    end

    assign is_letter = (r_ch >= 7'h41 && r_ch <= 7'h5a) || (r_ch >= 7'h61 && r_ch <= 7'h7a);
    assign is_digit  = (r_ch >= 7'h30 && r_ch <= 7'h39);

    always_comb begin
        o_stat.is_ws     = (r_ch == 7'h20) || (r_ch >= 7'd9 && r_ch <= 7'd13);
        o_stat.is_opnd   = is_digit;
        o_stat.is_letter = is_letter;
        o_stat.is_open   = (r_ch == C_OPEN);
        o_stat.is_close  = (r_ch == C_CLOSE);
        o_stat.is_not    = (r_ch == C_NOT);
        o_stat.op_empty  = (r_op_cnt == '0);
        o_stat.top_open  = (top_op == C_OPEN);
        o_stat.top_pops  = (prec(top_op) >= prec(r_ch));
        o_stat.vscan_end = r_hit || (r_scan >= r_var_cnt);
        o_stat.last      = r_last;
        o_stat.out_busy  = o_valid && i_stall;
    end

    // first error wins, several flags in one cycle taken in order
    logic [2:0]    e;
    logic [SC-1:0] n_op_cnt, n_ref_cnt;
    logic [VC-1:0] n_var_cnt;
    logic [NC-1:0] n_node_cnt;
    logic          emit;
    logic [1:0]    e_kind, e_lk, e_rk;
    logic [6:0]    e_sym;
    logic [3:0]    e_var;
    logic [5:0]    e_li, e_ri, e_node;
    logic          ref_we, op_we, var_we;
    logic [SW-1:0] ref_wa;
    logic [7:0]    ref_wd;
    logic [VW-1:0] vidx;
    logic [SC-1:0] rc;
    logic [5:0]    nidx;

    function automatic logic [2:0] fl(input logic [2:0] cur, input logic [2:0] code);
        fl = (cur == E_OK) ? code : cur;
    endfunction

    always_comb begin
        e = r_err;
        n_op_cnt = r_op_cnt;
        n_ref_cnt = r_ref_cnt;
        n_var_cnt = r_var_cnt;
        n_node_cnt = r_node_cnt;
        emit = 1'b0;
        e_kind = R_OPND; e_sym = r_ch; e_var = '0;
        e_lk = K_NONE; e_li = '0; e_rk = K_NONE; e_ri = '0; e_node = '0;
        ref_we = 1'b0; ref_wa = '0; ref_wd = '0;
        op_we = 1'b0; var_we = 1'b0;
        vidx = '0; rc = r_ref_cnt; nidx = '0;
        case (i_cmd.cmd)
            CMD_CHAR: begin
                if (r_ch == C_OPEN) begin
                    if (r_op_cnt < SC'(STACK_DEPTH)) begin
                        op_we = 1'b1;
                        n_op_cnt = r_op_cnt + 1'b1;
                    end else e = fl(e, E_OVF);
                end else begin
                    if (is_letter) begin
                        if (r_hit) vidx = r_hit_idx;
                        else if (r_var_cnt < VC'(MAX_VARS)) begin
                            vidx = VW'(r_var_cnt);
                            var_we = 1'b1;
                            n_var_cnt = r_var_cnt + 1'b1;
                        end else e = fl(e, E_VARS);
                        ref_wd = {K_VAR, 6'(vidx)};
                        e_var = 4'(vidx);
                    end else begin
                        ref_wd = {K_DIGIT, 6'(r_ch - 7'h30)};
                    end
                    if (r_ref_cnt < SC'(STACK_DEPTH)) begin
                        ref_we = 1'b1;
                        ref_wa = SW'(r_ref_cnt);
                        n_ref_cnt = r_ref_cnt + 1'b1;
                    end else e = fl(e, E_OVF);
                    emit = 1'b1;
                end
            end
            CMD_POP: begin
                n_op_cnt = r_op_cnt - 1'b1;
                e_kind = R_OPR;
                e_sym = top_op;
                if (top_op == C_NOT) begin
                    if (rc == '0) e = fl(e, E_MISS);
                    else begin
                        e_lk = ref_t[7:6]; e_li = ref_t[5:0]; rc = rc - 1'b1;
                    end
                end else begin
                    if (rc == '0) e = fl(e, E_MISS);
                    else begin
                        e_rk = ref_t[7:6]; e_ri = ref_t[5:0]; rc = rc - 1'b1;
                    end
                    if (rc == '0) e = fl(e, E_MISS);
                    else begin
                        e_lk = ref_u[7:6]; e_li = ref_u[5:0]; rc = rc - 1'b1;
                    end
                end
                if (r_node_cnt < NC'(MAX_NODES)) begin
                    nidx = 6'(r_node_cnt);
                    n_node_cnt = r_node_cnt + 1'b1;
                end else begin
                    e = fl(e, E_NODES);
                    nidx = 6'(MAX_NODES - 1);
                end
                e_node = nidx;
                if (rc < SC'(STACK_DEPTH)) begin
                    ref_we = 1'b1;
                    ref_wa = SW'(rc);
                    ref_wd = {K_NODE, nidx};
                    n_ref_cnt = rc + 1'b1;
                end else begin
                    e = fl(e, E_OVF);
                    n_ref_cnt = rc;
                end
                emit = 1'b1;
            end
            CMD_PUSH: begin
                if (r_op_cnt < SC'(STACK_DEPTH)) begin
                    op_we = 1'b1;
                    n_op_cnt = r_op_cnt + 1'b1;
                end else e = fl(e, E_OVF);
            end
            CMD_DROPP: begin
                // a matching '(' goes quietly, a stray ')' flags
                if (r_op_cnt != '0) n_op_cnt = r_op_cnt - 1'b1;
                else e = fl(e, E_PAREN);
            end
            CMD_FLUSHP: begin
                n_op_cnt = r_op_cnt - 1'b1;
                e = fl(e, E_PAREN);
            end
            CMD_DONE: begin
                if (r_ref_cnt == '0) e = fl(e, E_MISS);
                emit = 1'b1;
                e_kind = R_DONE;
                e_sym = '0;
            end
            default: ;
        endcase
    end

    logic [2:0] e_fin;
    assign e_fin = e;

    always_ff @(posedge i_clk) begin
        if (op_we) op_mem[SW'(r_op_cnt)] <= r_ch;
        if (ref_we) ref_mem[ref_wa] <= ref_wd;
        if (var_we) var_mem[VW'(r_var_cnt)] <= r_ch;
        if (i_take) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_cnt <= '0; r_ref_cnt <= '0; r_var_cnt <= '0;
            r_node_cnt <= '0; r_err <= E_OK;
            r_scan <= '0; r_hit <= 1'b0; r_hit_idx <= '0;
            o_valid <= 1'b0;
        end else begin
            if (emit) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            if (i_take) begin
                r_scan <= '0;
                r_hit  <= 1'b0;
            end else if (i_cmd.cmd == CMD_VSCAN) begin
                if (var_mem[VW'(r_scan)] == r_ch) begin
                    r_hit <= 1'b1;
                    r_hit_idx <= VW'(r_scan);
                end else r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.cmd == CMD_DONE) begin
                r_op_cnt <= '0; r_ref_cnt <= '0; r_var_cnt <= '0;
                r_node_cnt <= '0; r_err <= E_OK;
            end else begin
                r_op_cnt <= n_op_cnt; r_ref_cnt <= n_ref_cnt;
                r_var_cnt <= n_var_cnt; r_node_cnt <= n_node_cnt;
                r_err <= e_fin;
            end
            if (emit) begin
                o_result_kind <= e_kind;
                o_symbol      <= e_sym;
                o_var_index   <= e_var;
                o_left_kind   <= e_lk;
                o_left_index  <= e_li;
                o_right_kind  <= e_rk;
                o_right_index <= e_ri;
                o_node_index  <= e_node;
                o_status      <= e_fin;
                o_end_of_run  <= (e_kind == R_DONE);
            end
        end
    end
endmodule

### src/boolean_infix_to_postfix_tree.sv
// boolean infix to postfix tree builder, top level
// a digit result is registered into the output after its word is decoded; a letter
// result after its word is decoded and the variable table is scanned one entry at a time;
// a held output delays either. o_stall is high while a word is being handled, so a new
// word is taken only when the last one is finished. An operator or ')' first pops
// operators off the stack; the last word then flushes the stack and emits the done word
// reset: synchronous active low, clears all counters and the output valid
// depends on bitp_pkg, bitp_ctrl, bitp_dp
module boolean_infix_to_postfix_tree #(
    parameter int STACK_DEPTH = bitp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_VARS    = bitp_pkg::MAX_VARS_DEF,
    parameter int MAX_NODES   = bitp_pkg::MAX_NODES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [6:0] i_ch,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_result_kind,
    output logic [6:0] o_symbol,
    output logic [3:0] o_var_index,
    output logic [1:0] o_left_kind,
    output logic [5:0] o_left_index,
    output logic [1:0] o_right_kind,
    output logic [5:0] o_right_index,
    output logic [5:0] o_node_index,
    output logic [2:0] o_status,
    output logic       o_end_of_run
);
    import bitp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bitp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_stat(stat), .o_cmd(cmd)
    );

    bitp_dp #(.STACK_DEPTH(STACK_DEPTH), .MAX_VARS(MAX_VARS), .MAX_NODES(MAX_NODES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_take(i_valid && !o_stall), .i_ch(i_ch), .i_last(i_last),
        .i_cmd(cmd), .o_stat(stat),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_kind(o_result_kind), .o_symbol(o_symbol), .o_var_index(o_var_index),
        .o_left_kind(o_left_kind), .o_left_index(o_left_index),
        .o_right_kind(o_right_kind), .o_right_index(o_right_index),
        .o_node_index(o_node_index), .o_status(o_status), .o_end_of_run(o_end_of_run)
    );
endmodule
